FILE: rtl/kvll_pkg.sv
// ----------------------------------------------------------------------------
// kvll_pkg
// Shared types and constants for the key = value line lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kvll_pkg;

    localparam int KEY_BYTES   = 8;
    localparam int VALUE_MAX   = 63;

    localparam int KEY_TEXT_W  = 64;
    localparam int KEY_CNT_W   = 4;
    localparam int CAP_W       = 7;
    localparam int VAL_CNT_W   = 7;
    localparam int VAL_IDX_W   = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [KEY_CNT_W-1:0] KEY_CNT_MAX = 4'd15;
    localparam logic [VAL_CNT_W-1:0] VAL_CNT_MAX = 7'd127;
    localparam logic [CAP_W-1:0]     CAP_RESET   = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TEXT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_CAPACITY = 2'd2;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_FOUND    = 2'd1,
        KIND_NOTFOUND = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_KEY,
        PH_SKIP,
        PH_VLEAD,
        PH_VBODY
    } phase_t;

    typedef enum logic [1:0] {
        ST_SCAN,
        ST_PREP,
        ST_EMIT,
        ST_FOUND
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic prep;
        logic emit_byte;
        logic emit_found;
    } dp_cmd_t;

    typedef struct packed {
        logic need_emit;
        logic last_idx;
        logic out_free;
    } dp_status_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CHAR_SPACE, CHAR_TAB, CHAR_CR};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/kvll_channels.sv
// ----------------------------------------------------------------------------
// kvll channels
// Valid/ready channel interfaces for manifest bytes and lookup results.
// ----------------------------------------------------------------------------
`default_nettype none

interface kvll_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface kvll_out_if;
    logic                       valid;
    logic                       ready;
    kvll_pkg::kind_t            result_kind;
    logic [7:0]                 value_byte;
    logic [kvll_pkg::VAL_IDX_W-1:0] value_length;
    logic                       run_end;

    modport source (output valid, output result_kind, output value_byte,
                    output value_length, output run_end, input ready);
    modport sink   (input valid, input result_kind, input value_byte,
                    input value_length, input run_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/kvll_ctrl.sv
// ----------------------------------------------------------------------------
// kvll_ctrl
// Controller: scanning, value store priming, value emission and found status.
// ----------------------------------------------------------------------------
`default_nettype none

module kvll_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire kvll_pkg::dp_status_t st,
    output kvll_pkg::dp_cmd_t         cmd
);
    import kvll_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SCAN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SCAN:
            begin
                if (in_valid && st.out_free && st.need_emit)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (st.out_free && st.last_idx)
                begin
                    state_next = ST_FOUND;
                end
            end
            ST_FOUND:
            begin
                if (st.out_free)
                begin
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_SCAN;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_SCAN:
            begin
                in_ready   = st.out_free;
                cmd.accept = in_valid && st.out_free;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_byte = st.out_free;
            end
            ST_FOUND:
            begin
                cmd.emit_found = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/kvll_datapath.sv
// ----------------------------------------------------------------------------
// kvll_datapath
// Line parser state, configuration registers, value store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kvll_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [kvll_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [kvll_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [7:0]                          in_byte,
    input  wire logic                                in_last,
    input  wire kvll_pkg::dp_cmd_t                   cmd,
    output kvll_pkg::dp_status_t                     st,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output kvll_pkg::kind_t                          out_kind,
    output logic [7:0]                               out_byte,
    output logic [kvll_pkg::VAL_IDX_W-1:0]           out_len,
    output logic                                     out_end
);
    import kvll_pkg::*;

    logic [KEY_TEXT_W-1:0] key_text_reg;
    logic [KEY_CNT_W-1:0]  key_length_reg;
    logic [CAP_W-1:0]      value_capacity_reg;

    phase_t                phase_reg, phase_next;
    logic [KEY_CNT_W-1:0]  ksc_reg, ksc_next;
    logic                  keq_reg, keq_next;
    logic [KEY_CNT_W-1:0]  ktc_reg, ktc_next;
    logic                  kteq_reg, kteq_next;
    logic [VAL_CNT_W-1:0]  vsc_reg, vsc_next;
    logic [VAL_CNT_W-1:0]  vtc_reg, vtc_next;
    logic                  done_reg, done_next;

    logic [VAL_IDX_W-1:0]  n_reg;
    logic [VAL_IDX_W-1:0]  idx_reg, idx_next;

    logic [7:0]            mem [0:VALUE_MAX-1];
    logic [7:0]            rdata_reg;

    logic                  out_valid_reg;
    kind_t                 out_kind_reg;
    logic [7:0]            out_byte_reg;
    logic [VAL_IDX_W-1:0]  out_len_reg;
    logic                  out_end_reg;

    phase_t                ph_eff;
    logic                  blank_c;
    logic                  end_line;
    logic                  key_eq;
    logic                  too_long;
    logic                  wr_en;
    logic                  scan_load;
    kind_t                 scan_kind;
    logic [VAL_IDX_W-1:0]  scan_len;
    logic                  need_emit;
    logic                  out_free;

    // line parser
    always_comb
    begin
        blank_c    = is_blank(in_byte);
        phase_next = phase_reg;
        ksc_next   = ksc_reg;
        keq_next   = keq_reg;
        ktc_next   = ktc_reg;
        kteq_next  = kteq_reg;
        vsc_next   = vsc_reg;
        vtc_next   = vtc_reg;
        done_next  = done_reg;
        ph_eff     = phase_reg;
        end_line   = 1'b0;
        key_eq     = 1'b0;
        too_long   = 1'b0;
        wr_en      = 1'b0;
        scan_load  = 1'b0;
        scan_kind  = KIND_NOTFOUND;
        scan_len   = '0;
        need_emit  = 1'b0;
        if (!done_reg)
        begin
            if (in_byte != CHAR_LF)
            begin
                if (phase_reg == PH_START && !blank_c)
                begin
                    ph_eff = (in_byte == CHAR_HASH) ? PH_SKIP : PH_KEY;
                end
                else if (phase_reg == PH_VLEAD && !blank_c)
                begin
                    ph_eff = PH_VBODY;
                end
                phase_next = ph_eff;
                case (ph_eff)
                    PH_KEY:
                    begin
                        if (in_byte == CHAR_EQ)
                        begin
                            phase_next = (kteq_reg && ktc_reg == key_length_reg) ?
                                         PH_VLEAD : PH_SKIP;
                        end
                        else
                        begin
                            key_eq = keq_reg && (ksc_reg < key_length_reg) &&
                                     (ksc_reg < KEY_CNT_W'(KEY_BYTES)) &&
                                     (in_byte == key_text_reg[{ksc_reg[2:0], 3'b000} +: 8]);
                            keq_next = key_eq;
                            if (ksc_reg < KEY_CNT_MAX)
                            begin
                                ksc_next = ksc_reg + 1'b1;
                            end
                            if (!blank_c)
                            begin
                                ktc_next  = ksc_next;
                                kteq_next = key_eq;
                            end
                        end
                    end
                    PH_VBODY:
                    begin
                        wr_en = vsc_reg < VAL_CNT_W'(VALUE_MAX);
                        if (vsc_reg < VAL_CNT_MAX)
                        begin
                            vsc_next = vsc_reg + 1'b1;
                        end
                        if (!blank_c)
                        begin
                            vtc_next = vsc_next;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                end_line = in_last;
            end
            else
            begin
                end_line = 1'b1;
            end
            if (end_line)
            begin
                if (phase_next inside {PH_VLEAD, PH_VBODY})
                begin
                    done_next = 1'b1;
                    too_long  = (value_capacity_reg == '0) ||
                                ({1'b0, vtc_next} + 8'd1 > {1'b0, value_capacity_reg}) ||
                                (vtc_next > VAL_CNT_W'(VALUE_MAX));
                    if (too_long)
                    begin
                        scan_load = 1'b1;
                        scan_kind = KIND_ERROR;
                    end
                    else if (vtc_next == '0)
                    begin
                        scan_load = 1'b1;
                        scan_kind = KIND_FOUND;
                    end
                    else
                    begin
                        need_emit = 1'b1;
                        scan_len  = vtc_next[VAL_IDX_W-1:0];
                    end
                end
                phase_next = PH_START;
                ksc_next   = '0;
                keq_next   = 1'b1;
                ktc_next   = '0;
                kteq_next  = 1'b1;
                vsc_next   = '0;
                vtc_next   = '0;
            end
            if (in_last && !done_next)
            begin
                scan_load = 1'b1;
                scan_kind = (value_capacity_reg == '0) ? KIND_ERROR : KIND_NOTFOUND;
            end
        end
        if (in_last)
        begin
            done_next  = 1'b0;
            phase_next = PH_START;
            ksc_next   = '0;
            keq_next   = 1'b1;
            ktc_next   = '0;
            kteq_next  = 1'b1;
            vsc_next   = '0;
            vtc_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_text_reg       <= '0;
            key_length_reg     <= '0;
            value_capacity_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_TEXT:       key_text_reg       <= cfg_data;
                CFG_KEY_LENGTH:     key_length_reg     <= cfg_data[KEY_CNT_W-1:0];
                CFG_VALUE_CAPACITY: value_capacity_reg <= cfg_data[CAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            ksc_reg   <= '0;
            keq_reg   <= 1'b1;
            ktc_reg   <= '0;
            kteq_reg  <= 1'b1;
            vsc_reg   <= '0;
            vtc_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else if (cmd.accept)
        begin
            phase_reg <= phase_next;
            ksc_reg   <= ksc_next;
            keq_reg   <= keq_next;
            ktc_reg   <= ktc_next;
            kteq_reg  <= kteq_next;
            vsc_reg   <= vsc_next;
            vtc_reg   <= vtc_next;
            done_reg  <= done_next;
        end
    end

    // emission index; read data always tracks the next index
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.prep)
        begin
            idx_next = '0;
        end
        else if (cmd.emit_byte)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.accept && need_emit)
        begin
            n_reg <= scan_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
        begin
            mem[vsc_reg[VAL_IDX_W-1:0]] <= in_byte;
        end
        rdata_reg <= mem[idx_next];
    end

    // result register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.accept && scan_load) || cmd.emit_byte || cmd.emit_found)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && scan_load)
        begin
            out_kind_reg <= scan_kind;
            out_byte_reg <= '0;
            out_len_reg  <= scan_len;
            out_end_reg  <= 1'b1;
        end
        else if (cmd.emit_byte)
        begin
            out_kind_reg <= KIND_BYTE;
            out_byte_reg <= rdata_reg;
            out_len_reg  <= '0;
            out_end_reg  <= 1'b0;
        end
        else if (cmd.emit_found)
        begin
            out_kind_reg <= KIND_FOUND;
            out_byte_reg <= '0;
            out_len_reg  <= n_reg;
            out_end_reg  <= 1'b1;
        end
    end

    assign st.need_emit = need_emit;
    assign st.last_idx  = (idx_reg + 1'b1) == n_reg;
    assign st.out_free  = out_free;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_len   = out_len_reg;
    assign out_end   = out_end_reg;

endmodule

`default_nettype wire

FILE: rtl/key_value_line_lookup_unit.sv
// ----------------------------------------------------------------------------
// key_value_line_lookup_unit
// Streaming lookup of the first key = value line that matches a set key.
// ----------------------------------------------------------------------------
// Manifest bytes are taken one per cycle while the unit scans, as long as the
// result register is free or being drained. Lines that carry no match and all
// bytes after a decided result add no input stall. On the matching line end
// the unit holds off input to prime the value store read, then sends the n
// value bytes and the found status at one item per cycle when the result side
// is ready. Status items for not found, errors and empty values are loaded
// into the result register as the deciding byte is taken. The value store
// needs no clearing after reset. The user must write configuration through
// cfg_we, cfg_index and cfg_data only while idle; the unit does not check it.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_line_lookup_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    kvll_in_if.sink                              manifest,
    kvll_out_if.source                           result,
    input  wire logic                            cfg_we,
    input  wire logic [kvll_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kvll_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kvll_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_st;
    logic       in_ready;

    kvll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (manifest.valid),
        .in_ready (in_ready),
        .st       (dp_st),
        .cmd      (dp_cmd)
    );

    kvll_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (manifest.text_byte),
        .in_last   (manifest.final_byte),
        .cmd       (dp_cmd),
        .st        (dp_st),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_kind  (result.result_kind),
        .out_byte  (result.value_byte),
        .out_len   (result.value_length),
        .out_end   (result.run_end)
    );

    assign manifest.ready = in_ready;

`ifndef SYNTHESIS
    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.emit_byte || dp_cmd.emit_found) |-> dp_st.out_free)
        else $error("emission into an occupied result register");

    a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        (manifest.valid && in_ready) |-> !(dp_cmd.prep || dp_cmd.emit_byte ||
                                           dp_cmd.emit_found))
        else $error("input taken during value emission");

    a_prep_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.prep |=> !in_ready)
        else $error("input reopened right after store priming");
`endif

endmodule

`default_nettype wire
